// ----- rtl/ite_pkg.sv -----
// Shared types and constants for the index tuple enumerator.
// Used by ite_cell, ite_div and index_tuple_enumerator_unit.
package ite_pkg;

  localparam int MAX_SET    = 16;
  localparam int IDX_W      = $clog2(MAX_SET);
  localparam int CNT_W      = 5;
  localparam int BUD_W      = 48;
  localparam int PROD_W     = BUD_W + CNT_W;
  localparam int TUP_W      = MAX_SET * IDX_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

  localparam logic [BUD_W-1:0] BUDGET_RESET = BUD_W'(1048576);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_BLOCK = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_PART = 2'd1;
  localparam logic [1:0] MODE_COMB = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_K_GT_N = 2'd1;
  localparam logic [1:0] ST_BUDGET = 2'd2;
  localparam logic [1:0] ST_NO_ROW = 2'd3;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_BUDGET = 1'b1;

  typedef enum logic [1:0] {
    CC_HOLD,
    CC_LOAD,
    CC_SET,
    CC_COMB
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] pos_val;
    logic [CNT_W-1:0] nc_val;
    logic             nc_clr;
    logic [IDX_W-1:0] nc_sel;
    logic [CNT_W-1:0] row_n;
    logic [CNT_W-1:0] row_k;
    logic [IDX_W-1:0] base;
  } cell_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] nc;
    logic             hi_out;
    logic             lst_out;
    logic             pivot;
  } cell_stat_t;

endpackage

// ----- rtl/index_tuple_enumerator_unit.sv -----
// Index tuple enumerator: lexicographic permutations, partial permutations
// and combinations of up to 16 indexes, one result word per input word and one
// word in flight; in_stall stays high from acceptance until the result word is
// loaded into the output register. A start word runs the budget division, then
// the count factors (in combination mode each factor runs the one-bit-per-cycle
// divider), then loads, charges and emits the first tuple; a failed count check
// ends early. A next word in permutation mode also runs the candidate scan and
// backtrack steps of the position sequencer. New-block, unused-op, no-row,
// rejected and empty-tuple words go straight to the output stage, and a word
// held by a stalled output waits there until the output register frees.
// Depends on ite_pkg, ite_cell, ite_div.
module index_tuple_enumerator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [4:0]                  in_set_size,
  input  logic [4:0]                  in_pick_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ite_pkg::TUP_W-1:0]   out_index_tuple,
  output logic [4:0]                  out_tuple_length,
  output logic                        out_last_variant,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ite_pkg::BUD_W-1:0]   cfg_wdata
);
  import ite_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LIMDIV, S_CTEST, S_CCHK, S_CDIV, S_LMUL, S_LADD,
    S_COMB, S_PINIT, S_SCAN, S_EMIT, S_FIN
  } state_t;

  state_t           state_r;
  logic [1:0]       mode_reg_r, mode_r;
  logic [BUD_W-1:0] budget_r, gen_r, lim_r, r_r;
  logic [PROD_W-1:0] p_r, div_a_r, div_q;
  logic [CNT_W-1:0] div_b_r, n_r, k_r, row_n_r, row_k_r, sd_r, d_r, i_r;
  logic             div_go_r, div_done, row_active_r;
  logic [MAX_SET-1:0] used_r;
  logic [TUP_W-1:0] res_tuple_r;
  logic [4:0]       res_len_r;
  logic             res_last_r;
  logic [1:0]       res_st_r;
  logic             out_valid_r, out_last_r;
  logic [TUP_W-1:0] out_tuple_r;
  logic [4:0]       out_len_r;
  logic [1:0]       out_st_r;

  cell_ctl_t        ctl;
  cell_stat_t       cst [MAX_SET];
  logic [MAX_SET-1:0] hi_in, lst_in;

  logic             accept;
  logic [CNT_W-1:0] n_sat, k_in, m_w, f_w;
  logic [BUD_W-1:0] remain;
  logic             cond;
  logic [IDX_W-1:0] piv_pos, piv_idx, c_w;
  logic             found;
  logic [MAX_SET-1:0] cand;
  logic [CNT_W-1:0] nc_d;
  logic [TUP_W-1:0] pack_w;
  logic             last_w;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign n_sat  = (in_set_size > CNT_W'(MAX_SET)) ? CNT_W'(MAX_SET) : in_set_size;
  assign k_in   = (mode_reg_r == MODE_FULL) ? n_sat : in_pick_count;
  assign remain = (budget_r > gen_r) ? budget_r - gen_r : '0;
  assign m_w    = (k_r == n_r) ? '0 : ((k_r < n_r - k_r) ? k_r : n_r - k_r);
  assign f_w    = (mode_r == MODE_FULL) ? i_r : n_r - i_r;

  always_comb begin
    case (mode_r)
      MODE_FULL: cond = i_r <= n_r;
      MODE_PART: cond = i_r < k_r;
      default:   cond = i_r < m_w;
    endcase
  end

  ite_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quot     (div_q)
  );

  for (genvar g = 0; g < MAX_SET; g++) begin : g_cell
    if (g == MAX_SET - 1) begin : g_top
      assign hi_in[g]  = 1'b1;
      assign lst_in[g] = 1'b1;
    end else begin : g_mid
      assign hi_in[g]  = cst[g+1].hi_out;
      assign lst_in[g] = cst[g+1].lst_out;
    end
    ite_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (ctl),
      .hi_in    (hi_in[g]),
      .lst_in   (lst_in[g]),
      .stat     (cst[g])
    );
  end

  always_comb begin
    piv_pos = '0;
    piv_idx = '0;
    pack_w  = '0;
    for (int j = 0; j < MAX_SET; j++) begin
      if (cst[j].pivot) begin
        piv_pos = piv_pos | cst[j].pos;
        piv_idx = piv_idx | IDX_W'(j);
      end
      if (CNT_W'(j) < row_k_r) pack_w[IDX_W*j +: IDX_W] = cst[j].pos;
    end
  end

  assign nc_d = cst[d_r[IDX_W-1:0]].nc;

  always_comb begin
    c_w   = '0;
    found = 1'b0;
    for (int j = 0; j < MAX_SET; j++) begin
      cand[j] = !used_r[j] && (CNT_W'(j) >= nc_d) && (CNT_W'(j) < row_n_r);
    end
    for (int j = MAX_SET - 1; j >= 0; j--) begin
      if (cand[j]) begin
        c_w   = IDX_W'(j);
        found = 1'b1;
      end
    end
  end

  assign last_w = (mode_reg_r >= MODE_COMB)
                ? (CNT_W'(cst[0].pos) == row_n_r - row_k_r)
                : cst[0].lst_out;

  always_comb begin
    ctl.cmd     = CC_HOLD;
    ctl.sel     = d_r[IDX_W-1:0];
    ctl.pos_val = c_w;
    ctl.nc_val  = CNT_W'(c_w) + CNT_W'(1);
    ctl.nc_clr  = (d_r + CNT_W'(1)) < row_k_r;
    ctl.nc_sel  = IDX_W'(d_r + CNT_W'(1));
    ctl.row_n   = row_n_r;
    ctl.row_k   = row_k_r;
    ctl.base    = piv_pos + IDX_W'(1) - piv_idx;
    case (state_r)
      S_LMUL: ctl.cmd = CC_LOAD;
      S_COMB: ctl.cmd = cst[0].hi_out ? CC_HOLD : CC_COMB;
      S_SCAN: ctl.cmd = found ? CC_SET : CC_HOLD;
      default: ctl.cmd = CC_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_reg_r   <= MODE_FULL;
      budget_r     <= BUDGET_RESET;
      gen_r        <= '0;
      row_active_r <= 1'b0;
      used_r       <= '0;
      sd_r         <= '0;
      row_n_r      <= '0;
      row_k_r      <= '0;
      div_go_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_MODE) begin
          mode_reg_r   <= cfg_wdata[1:0];
          row_active_r <= 1'b0;
        end else begin
          budget_r <= cfg_wdata;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_tuple_r <= '0;
            res_len_r   <= '0;
            res_last_r  <= 1'b0;
            res_st_r    <= ST_OK;
            state_r     <= S_FIN;
            case (in_op)
              OP_BLOCK: begin
                gen_r        <= '0;
                row_active_r <= 1'b0;
              end
              OP_START: begin
                row_active_r <= 1'b0;
                if (k_in > n_sat) begin
                  res_st_r <= ST_K_GT_N;
                end else if (k_in == '0) begin
                  res_last_r <= 1'b1;
                end else begin
                  n_r      <= n_sat;
                  k_r      <= k_in;
                  mode_r   <= (mode_reg_r >= MODE_COMB) ? MODE_COMB : mode_reg_r;
                  div_a_r  <= PROD_W'(remain);
                  div_b_r  <= k_in;
                  div_go_r <= 1'b1;
                  state_r  <= S_LIMDIV;
                end
              end
              OP_NEXT: begin
                if (!row_active_r)                res_st_r <= ST_NO_ROW;
                else if (mode_reg_r >= MODE_COMB) state_r  <= S_COMB;
                else                              state_r  <= S_PINIT;
              end
              default: res_st_r <= ST_NO_ROW;
            endcase
          end
        end
        S_LIMDIV: begin
          if (div_done) begin
            lim_r   <= div_q[BUD_W-1:0];
            r_r     <= BUD_W'(1);
            i_r     <= (mode_r == MODE_FULL) ? CNT_W'(2) : '0;
            state_r <= S_CTEST;
          end
        end
        S_CTEST: begin
          p_r <= PROD_W'(r_r) * PROD_W'(f_w);
          if (cond) begin
            state_r <= S_CCHK;
          end else if (r_r > lim_r) begin
            res_st_r <= ST_BUDGET;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_LMUL;
          end
        end
        S_CCHK: begin
          if (mode_r == MODE_COMB) begin
            div_a_r  <= p_r;
            div_b_r  <= i_r + CNT_W'(1);
            div_go_r <= 1'b1;
            state_r  <= S_CDIV;
          end else if (p_r > PROD_W'(lim_r)) begin
            res_st_r <= ST_BUDGET;
            state_r  <= S_FIN;
          end else begin
            r_r     <= p_r[BUD_W-1:0];
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_CTEST;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            if (div_q > PROD_W'(lim_r)) begin
              res_st_r <= ST_BUDGET;
              state_r  <= S_FIN;
            end else begin
              r_r     <= div_q[BUD_W-1:0];
              i_r     <= i_r + CNT_W'(1);
              state_r <= S_CTEST;
            end
          end
        end
        S_LMUL: begin
          p_r     <= PROD_W'(r_r) * PROD_W'(k_r);
          for (int j = 0; j < MAX_SET; j++) used_r[j] <= CNT_W'(j) < k_r;
          sd_r    <= k_r;
          row_n_r <= n_r;
          row_k_r <= k_r;
          state_r <= S_LADD;
        end
        S_LADD: begin
          gen_r        <= gen_r + p_r[BUD_W-1:0];
          row_active_r <= 1'b1;
          state_r      <= S_EMIT;
        end
        S_COMB: begin
          if (cst[0].hi_out) begin
            row_active_r <= 1'b0;
            res_st_r     <= ST_NO_ROW;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_PINIT: begin
          if (sd_r == '0 || sd_r > row_k_r) begin
            row_active_r <= 1'b0;
            res_st_r     <= ST_NO_ROW;
            state_r      <= S_FIN;
          end else begin
            d_r <= sd_r - CNT_W'(1);
            used_r[cst[IDX_W'(sd_r - CNT_W'(1))].pos] <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            used_r[c_w] <= 1'b1;
            d_r         <= d_r + CNT_W'(1);
            if (d_r + CNT_W'(1) == row_k_r) begin
              sd_r    <= row_k_r;
              state_r <= S_EMIT;
            end
          end else if (d_r == '0) begin
            sd_r         <= '0;
            row_active_r <= 1'b0;
            res_st_r     <= ST_NO_ROW;
            state_r      <= S_FIN;
          end else begin
            d_r <= d_r - CNT_W'(1);
            used_r[cst[IDX_W'(d_r - CNT_W'(1))].pos] <= 1'b0;
          end
        end
        S_EMIT: begin
          res_tuple_r <= pack_w;
          res_len_r   <= row_k_r;
          res_last_r  <= last_w;
          res_st_r    <= ST_OK;
          if (last_w) row_active_r <= 1'b0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_tuple_r <= res_tuple_r;
            out_len_r   <= res_len_r;
            out_last_r  <= res_last_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_index_tuple  = out_tuple_r;
  assign out_tuple_length = out_len_r;
  assign out_last_variant = out_last_r;
  assign out_status       = out_st_r;

  a_scan_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (d_r < row_k_r))
    else $error("scan depth beyond tuple length");

  a_row_shape: assert property (@(posedge clk) disable iff (!rst_n)
    row_active_r |-> (row_k_r != '0 && row_k_r <= row_n_r))
    else $error("active row with bad shape");

  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> row_active_r)
    else $error("tuple emitted without active row");

endmodule

// ----- rtl/ite_cell.sv -----
// One tuple position: index and next candidate, with the max/last chains.
// Depends on ite_pkg.
module ite_cell (
  input  logic                    clk,
  input  logic [ite_pkg::IDX_W-1:0] cell_idx,
  input  ite_pkg::cell_ctl_t      ctl,
  input  logic                    hi_in,
  input  logic                    lst_in,
  output ite_pkg::cell_stat_t     stat
);
  import ite_pkg::*;

  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] nc_r, nc_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic             live, at_max, at_end;

  assign idx_ext = CNT_W'(cell_idx);
  assign live    = idx_ext < ctl.row_k;
  assign at_max  = !live || (CNT_W'(pos_r) == ctl.row_n - ctl.row_k + idx_ext);
  assign at_end  = !live || (CNT_W'(pos_r) == ctl.row_n - CNT_W'(1) - idx_ext);

  always_comb begin
    pos_nxt = pos_r;
    nc_nxt  = nc_r;
    case (ctl.cmd)
      CC_LOAD: begin
        pos_nxt = cell_idx;
        nc_nxt  = idx_ext + CNT_W'(1);
      end
      CC_SET: begin
        if (ctl.sel == cell_idx) begin
          pos_nxt = ctl.pos_val;
          nc_nxt  = ctl.nc_val;
        end
        if (ctl.nc_clr && ctl.nc_sel == cell_idx) begin
          nc_nxt = '0;
        end
      end
      CC_COMB: begin
        if (live && hi_in) begin
          if (!at_max) pos_nxt = pos_r + IDX_W'(1);
          else         pos_nxt = ctl.base + cell_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    nc_r  <= nc_nxt;
  end

  assign stat.pos     = pos_r;
  assign stat.nc      = nc_r;
  assign stat.hi_out  = hi_in && at_max;
  assign stat.lst_out = lst_in && at_end;
  assign stat.pivot   = live && hi_in && !at_max;

endmodule

// ----- rtl/ite_div.sv -----
// Restoring divider, one quotient bit per cycle, small divisor.
// Depends on ite_pkg.
module ite_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ite_pkg::PROD_W-1:0] dividend,
  input  logic [ite_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [ite_pkg::PROD_W-1:0] quot
);
  import ite_pkg::*;

  logic [PROD_W-1:0]    q_r;
  logic [CNT_W-1:0]     rem_r, b_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [CNT_W:0]       trial;
  logic                 ge;

  assign trial   = {rem_r, q_r[PROD_W-1]};
  assign ge      = trial >= {1'b0, b_r};
  assign rem_nxt = ge ? CNT_W'(trial - {1'b0, b_r}) : CNT_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= dividend;
        rem_r <= '0;
        b_r   <= divisor;
        cnt_r <= DIV_CNT_W'(PROD_W);
      end else if (cnt_r != '0) begin
        q_r    <= {q_r[PROD_W-2:0], ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - DIV_CNT_W'(1);
        done_r <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
